// ===== rtl/core/lte_pkg.sv =====
// Shared types and codes for the lease table engine.
// Used by the slot cell, the top level and the testbench.
package lte_pkg;

    localparam int ENTRIES = 16;

    localparam logic [31:0] LEASE_DURATION_RST = 32'd86400;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_LOOKUP = 2'd1;
    localparam logic [1:0] CMD_DELETE = 2'd2;
    localparam logic [1:0] CMD_EXPIRE = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    // Command token that walks down the row of slot cells.
    typedef struct packed {
        logic        active;
        logic        done;
        logic [1:0]  command;
        logic [47:0] mac;
        logic [31:0] ip;
        logic [31:0] now;
        logic [1:0]  status;
        logic [31:0] result_ip;
        logic [47:0] result_mac;
        logic [3:0]  slot;
    } t_beat;

endpackage

// ===== rtl/core/lte_cmd_if.sv =====
// Command channel of the lease table engine: valid/ready plus command fields.
// Depends on nothing but plain logic widths.
interface lte_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [47:0] mac;
    logic [31:0] ip;
    logic [31:0] now;

    modport source (output valid, output command, output mac, output ip, output now,
                    input ready);
    modport sink   (input valid, input command, input mac, input ip, input now,
                    output ready);
endinterface

// ===== rtl/core/lte_rsp_if.sv =====
// Response channel of the lease table engine: valid/ready plus result fields.
// Depends on nothing but plain logic widths.
interface lte_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] result_ip;
    logic [47:0] result_mac;
    logic [3:0]  slot;

    modport source (output valid, output status, output result_ip, output result_mac,
                    output slot, input ready);
    modport sink   (input valid, input status, input result_ip, input result_mac,
                    input slot, output ready);
endinterface

// ===== rtl/core/lte_cell.sv =====
// One slot of the lease table: holds valid, mac, ip and lease start, and
// acts on the command token as it passes. Depends on lte_pkg.
module lte_cell
    import lte_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [3:0]  i_index,
    input  logic [31:0] i_lease_duration,
    input  t_beat       i_beat,
    output t_beat       o_beat
);

    logic        r_valid, n_valid;
    logic [47:0] r_mac;
    logic [31:0] r_ip;
    logic [31:0] r_start;
    t_beat       r_beat, n_beat;
    logic        w_write;
    logic        w_mac_eq;
    logic [31:0] w_elapsed;

    assign w_mac_eq  = (r_mac == i_beat.mac);
    assign w_elapsed = i_beat.now - r_start;

    always_comb begin
        n_beat  = i_beat;
        n_valid = r_valid;
        w_write = 1'b0;
        if (i_beat.active && !i_beat.done) begin
            unique case (i_beat.command)
                CMD_INSERT: begin
                    if (!r_valid) begin
                        w_write       = 1'b1;
                        n_valid       = 1'b1;
                        n_beat.done   = 1'b1;
                        n_beat.status = ST_OK;
                        n_beat.slot   = i_index;
                    end
                end
                CMD_LOOKUP: begin
                    if (r_valid && w_mac_eq) begin
                        n_beat.done       = 1'b1;
                        n_beat.status     = ST_OK;
                        n_beat.result_ip  = r_ip;
                        n_beat.result_mac = r_mac;
                        n_beat.slot       = i_index;
                    end
                end
                CMD_DELETE: begin
                    if (r_valid && w_mac_eq) begin
                        n_valid       = 1'b0;
                        n_beat.done   = 1'b1;
                        n_beat.status = ST_OK;
                        n_beat.slot   = i_index;
                    end
                end
                CMD_EXPIRE: begin
                    // elapsed time wraps modulo 2^32
                    if (r_valid && (w_elapsed >= i_lease_duration)) begin
                        n_beat.done       = 1'b1;
                        n_beat.status     = ST_OK;
                        n_beat.result_ip  = r_ip;
                        n_beat.result_mac = r_mac;
                        n_beat.slot       = i_index;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid       <= 1'b0;
            r_beat.active <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_beat  <= n_beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_write) begin
            r_mac   <= i_beat.mac;
            r_ip    <= i_beat.ip;
            r_start <= i_beat.now;
        end
    end

    assign o_beat = r_beat;

endmodule

// ===== rtl/core/lease_table_engine.sv =====
// Lease table engine top level: a row of ENTRIES slot cells, the lease
// duration register and the response register.
// Depends on lte_pkg, lte_cmd_if, lte_rsp_if and lte_cell.
//
// Usage:
//   i_cmd carries one command per beat (insert, look up, delete, find
//   expired). o_rsp returns exactly one result beat per command.
//   i_cfg_we / i_cfg_wdata write the lease duration; write only while idle.
// Timing:
//   An accepted command travels down the row of cells, one slot per cycle,
//   and the first slot that matches acts on it. Each cell registers the
//   token, and the response register captures it off the end of the row.
//   One command is in flight at a time: a new command is taken only once
//   the result beat of the last one has been taken.
// Reset:
//   All slots become free, the lease duration returns to 86400 and both
//   channels go idle.
// Stall:
//   The result holds in the output register while o_rsp.ready is low, and
//   i_cmd.ready stays low until the result beat is taken.
module lease_table_engine
    import lte_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    lte_cmd_if.sink     i_cmd,
    lte_rsp_if.source   o_rsp,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata
);

    logic        r_busy;
    logic        r_out_valid;
    logic [31:0] r_lease_duration;
    logic [1:0]  r_status;
    logic [31:0] r_result_ip;
    logic [47:0] r_result_mac;
    logic [3:0]  r_slot;
    logic        w_accept;
    logic        w_take;
    t_beat       w_head;
    t_beat       w_chain [ENTRIES+1];
    t_beat       w_tail;

    assign i_cmd.ready = !r_busy;
    assign w_accept    = i_cmd.valid && !r_busy;
    assign w_take      = r_out_valid && o_rsp.ready;

    always_comb begin
        w_head            = '0;
        w_head.active     = w_accept;
        w_head.command    = i_cmd.command;
        w_head.mac        = i_cmd.mac;
        w_head.ip         = i_cmd.ip;
        w_head.now        = i_cmd.now;
        w_head.status     = ST_NOT_FOUND;
    end

    assign w_chain[0] = w_head;

    for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
        lte_cell u_cell (
            .i_clk            (i_clk),
            .i_rst_n          (i_rst_n),
            .i_index          (4'(k)),
            .i_lease_duration (r_lease_duration),
            .i_beat           (w_chain[k]),
            .o_beat           (w_chain[k+1])
        );
    end

    assign w_tail = w_chain[ENTRIES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy           <= 1'b0;
            r_out_valid      <= 1'b0;
            r_lease_duration <= LEASE_DURATION_RST;
        end else begin
            if (i_cfg_we) begin
                r_lease_duration <= i_cfg_wdata;
            end
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_take) begin
                r_busy <= 1'b0;
            end
            if (w_tail.active) begin
                r_out_valid <= 1'b1;
            end else if (w_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // capture the token off the end of the row; if unmatched: full on insert, miss otherwise
    always_ff @(posedge i_clk) begin
        if (w_tail.active) begin
            if (w_tail.done) begin
                r_status     <= w_tail.status;
                r_result_ip  <= w_tail.result_ip;
                r_result_mac <= w_tail.result_mac;
                r_slot       <= w_tail.slot;
            end else begin
                r_status     <= (w_tail.command == CMD_INSERT) ? ST_FULL : ST_NOT_FOUND;
                r_result_ip  <= '0;
                r_result_mac <= '0;
                r_slot       <= '0;
            end
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_status;
    assign o_rsp.result_ip  = r_result_ip;
    assign o_rsp.result_mac = r_result_mac;
    assign o_rsp.slot       = r_slot;

    a_no_accept_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !i_cmd.ready)
        else $error("command accepted while a result is pending");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_busy && !r_out_valid))
        else $error("engine not busy after command beat");

    a_tail_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tail.active |-> (r_busy && !r_out_valid))
        else $error("token reached row end with no command in flight");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_status != ST_OK)) |->
            ((r_result_ip == '0) && (r_result_mac == '0) && (r_slot == '0)))
        else $error("failed command returned nonzero fields");

endmodule

// ===== dv/lease_table_engine_test.sv =====
`timescale 1ns / 1ps
// Self-checking test of lease_table_engine: directed and random command traffic
// against a built-in lease table predictor. Depends on lte_pkg, lte_cmd_if, lte_rsp_if and lease_table_engine.
module lease_table_engine_test;
    import lte_pkg::*;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] ip;
        logic [47:0] mac;
        logic [3:0]  slot;
    } t_lease_reply;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [31:0] i_cfg_wdata;

    lte_cmd_if cmd_ch ();
    lte_rsp_if rsp_ch ();

    lease_table_engine dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_ch),
        .o_rsp       (rsp_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #2 i_clk = ~i_clk;

    // predicted table contents
    logic        tbl_valid [ENTRIES];
    logic [47:0] tbl_mac   [ENTRIES];
    logic [31:0] tbl_ip    [ENTRIES];
    logic [31:0] tbl_start [ENTRIES];
    logic [31:0] lease_len;

    t_lease_reply lease_replies_due [$];
    int           mismatch_count;
    int           src_idle_pct;
    int           sink_idle_pct;
    int           hold_off_cycles;
    logic [47:0]  mac_pool [12];
    logic [31:0]  sim_secs;

    function automatic t_lease_reply lease_table_predict(input logic [1:0] op,
                                                         input logic [47:0] mac,
                                                         input logic [31:0] ip,
                                                         input logic [31:0] now);
        t_lease_reply r;
        int           hit;
        int           k;
        logic [31:0]  elapsed;
        r   = '{status: ST_NOT_FOUND, ip: '0, mac: '0, slot: '0};
        hit = -1;
        case (op)
            CMD_INSERT: begin
                for (k = 0; k < ENTRIES; k++)
                    if (hit < 0 && !tbl_valid[k]) hit = k;
                if (hit < 0) begin
                    r.status = ST_FULL;
                end else begin
                    tbl_valid[hit] = 1'b1;
                    tbl_mac[hit]   = mac;
                    tbl_ip[hit]    = ip;
                    tbl_start[hit] = now;
                    r.status       = ST_OK;
                    r.slot         = 4'(hit);
                end
            end
            CMD_LOOKUP, CMD_DELETE: begin
                for (k = 0; k < ENTRIES; k++)
                    if (hit < 0 && tbl_valid[k] && tbl_mac[k] == mac) hit = k;
                if (hit >= 0) begin
                    r.status = ST_OK;
                    r.slot   = 4'(hit);
                    if (op == CMD_LOOKUP) begin
                        r.ip  = tbl_ip[hit];
                        r.mac = tbl_mac[hit];
                    end else begin
                        tbl_valid[hit] = 1'b0;
                    end
                end
            end
            default: begin
                for (k = 0; k < ENTRIES; k++) begin
                    elapsed = now - tbl_start[k];
                    if (hit < 0 && tbl_valid[k] && elapsed >= lease_len) hit = k;
                end
                if (hit >= 0) begin
                    r.status = ST_OK;
                    r.ip     = tbl_ip[hit];
                    r.mac    = tbl_mac[hit];
                    r.slot   = 4'(hit);
                end
            end
        endcase
        return r;
    endfunction

    task automatic send_lease_cmd(input logic [1:0] op, input logic [47:0] mac,
                                  input logic [31:0] ip, input logic [31:0] now);
        while ($urandom_range(99) < src_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_ch.valid   <= 1'b1;
        cmd_ch.command <= op;
        cmd_ch.mac     <= mac;
        cmd_ch.ip      <= ip;
        cmd_ch.now     <= now;
        do @(posedge i_clk); while (!cmd_ch.ready);
        lease_replies_due.push_back(lease_table_predict(op, mac, ip, now));
    endtask

    task automatic drain_replies;
        cmd_ch.valid <= 1'b0;
        while (lease_replies_due.size() != 0) @(posedge i_clk);
        repeat (ENTRIES + 4) @(posedge i_clk);
    endtask

    task automatic set_lease_duration(input logic [31:0] secs);
        drain_replies();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= secs;
        @(posedge i_clk);
        lease_len = secs;
        i_cfg_we <= 1'b0;
    endtask

    task automatic test_empty_table;
        send_lease_cmd(CMD_EXPIRE, 48'h0, 32'h0, 32'h0);
        send_lease_cmd(CMD_LOOKUP, '1, 32'h0, 32'h0);
    endtask

    // slot 1 starts at the top of the time range, so expiry has to wrap
    task automatic test_insert_extremes;
        send_lease_cmd(CMD_INSERT, 48'h0, 32'h0, 32'h0);
        send_lease_cmd(CMD_INSERT, '1, '1, '1);
        send_lease_cmd(CMD_LOOKUP, '1, 32'h0, 32'h0);
        send_lease_cmd(CMD_EXPIRE, 48'h0, 32'h0, LEASE_DURATION_RST - 32'd1);
        send_lease_cmd(CMD_EXPIRE, 48'h0, 32'h0, LEASE_DURATION_RST);
    endtask

    task automatic test_fill_and_duplicates;
        int k;
        for (k = 2; k < ENTRIES; k++)
            send_lease_cmd(CMD_INSERT, (k == 3) ? 48'hA5A5_0000_0002 : 48'hA5A5_0000_0000 + k,
                           $urandom, $urandom);
        send_lease_cmd(CMD_INSERT, 48'h1234_5678_9ABC, $urandom, $urandom);
        send_lease_cmd(CMD_LOOKUP, 48'hA5A5_0000_0002, 32'h0, 32'h0);
        send_lease_cmd(CMD_DELETE, 48'hA5A5_0000_0002, 32'h0, 32'h0);
        send_lease_cmd(CMD_DELETE, 48'hA5A5_0000_0000 + ENTRIES - 1, 32'h0, 32'h0);
        send_lease_cmd(CMD_DELETE, 48'h0, 32'h0, 32'h0);
    endtask

    task automatic test_random_traffic(input int n_items);
        int          i;
        int          roll;
        int          pick;
        logic [1:0]  op;
        logic [47:0] mac;
        logic [31:0] now;
        for (i = 0; i < n_items; i++) begin
            roll = $urandom_range(99);
            op   = (roll < 30) ? CMD_INSERT : (roll < 55) ? CMD_LOOKUP :
                   (roll < 85) ? CMD_DELETE : CMD_EXPIRE;
            mac  = ($urandom_range(9) < 8) ? mac_pool[$urandom_range(11)]
                                           : 48'({$urandom, $urandom});
            sim_secs = sim_secs + 32'($urandom_range(3000));
            now  = ($urandom_range(9) == 0) ? 32'($urandom) : sim_secs;
            pick = $urandom_range(ENTRIES - 1);
            // land right on the expiry boundary of a live slot
            if (op == CMD_EXPIRE && tbl_valid[pick] && $urandom_range(1))
                now = tbl_start[pick] + lease_len - 32'd1 + 32'($urandom_range(2));
            send_lease_cmd(op, mac, $urandom, now);
        end
    endtask

    task automatic test_output_stall;
        hold_off_cycles = 400;
        test_random_traffic(30);
    endtask

    // response sink with random stalls and an optional long hold-off
    initial begin
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_cycles > 0) begin
                hold_off_cycles--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_lease_reply want;
        t_lease_reply got;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            got = '{status: rsp_ch.status, ip: rsp_ch.result_ip, mac: rsp_ch.result_mac,
                    slot: rsp_ch.slot};
            if (lease_replies_due.size() == 0) begin
                $display("%0t: reply beat with none due: status=%0d ip=%h mac=%h slot=%0d",
                         $time, got.status, got.ip, got.mac, got.slot);
                mismatch_count++;
            end else begin
                want = lease_replies_due.pop_front();
                if (got !== want) begin
                    $display("%0t: expected status=%0d ip=%h mac=%h slot=%0d", $time,
                             want.status, want.ip, want.mac, want.slot);
                    $display("%0t: actual   status=%0d ip=%h mac=%h slot=%0d", $time,
                             got.status, got.ip, got.mac, got.slot);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        int k;
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_wdata    <= '0;
        cmd_ch.valid   <= 1'b0;
        cmd_ch.command <= CMD_INSERT;
        cmd_ch.mac     <= '0;
        cmd_ch.ip      <= '0;
        cmd_ch.now     <= '0;
        mismatch_count  = 0;
        hold_off_cycles = 0;
        src_idle_pct    = 13;
        sink_idle_pct   = 81;
        lease_len       = LEASE_DURATION_RST;
        sim_secs        = 32'($urandom);
        for (k = 0; k < ENTRIES; k++) begin
            tbl_valid[k] = 1'b0;
            tbl_mac[k]   = '0;
            tbl_ip[k]    = '0;
            tbl_start[k] = '0;
        end
        mac_pool[0] = '0;
        mac_pool[1] = '1;
        for (k = 2; k < 12; k++) mac_pool[k] = 48'({$urandom, $urandom});
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_table();
        test_insert_extremes();
        test_fill_and_duplicates();

        set_lease_duration(32'h0);
        test_random_traffic(180);
        set_lease_duration(32'hFFFF_FFFF);
        test_random_traffic(180);

        src_idle_pct  = 81;
        sink_idle_pct = 13;
        set_lease_duration(32'($urandom_range(5000, 1)));
        test_random_traffic(180);
        set_lease_duration(32'd1);
        test_random_traffic(180);

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        set_lease_duration(LEASE_DURATION_RST);
        test_random_traffic(150);
        set_lease_duration(32'd20000);
        test_output_stall();
        test_random_traffic(180);

        drain_replies();
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #(4_000_000);
        $display("Regression FAIL");
        $finish;
    end

endmodule
